### hdl/assert_macros.svh
// Assertion macros shared by the receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, expr, msg) \
   `ASSERT_CLK(label, !(expr), msg)

`endif

### hdl/crc8pfr_pkg.sv
// Types, constants and the CRC-8 byte update for the framed packet receiver.
package crc8pfr_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] CRC_INIT    = 8'h00;

   localparam logic [8:0] POS_SYNC_FIRST  = 9'd0;
   localparam logic [8:0] POS_SYNC_SECOND = 9'd1;
   localparam logic [8:0] POS_TYPE        = 9'd2;
   localparam logic [8:0] POS_TOTAL       = 9'd4;
   localparam logic [8:0] POS_SEQ         = 9'd5;
   localparam logic [8:0] POS_LEN         = 9'd6;
   localparam logic [8:0] POS_CRC         = 9'd7;
   localparam logic [8:0] POS_PAYLOAD     = 9'd8;
   localparam logic [8:0] POS_MAX         = 9'd511;

   localparam logic [7:0] TYPE_DATA  = 8'd1;
   localparam logic [7:0] TYPE_START = 8'd2;
   localparam logic [7:0] TYPE_STOP  = 8'd3;

   localparam logic [7:0] SEQ_FIRST = 8'd1;

   typedef enum logic {
      REPLY_ACK  = 1'b0,
      REPLY_NACK = 1'b1
   } reply_kind_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_START     = 3'd1,
      EV_STOP      = 3'd2,
      EV_STORED    = 3'd3,
      EV_COMPLETE  = 3'd4,
      EV_OVERFLOW  = 3'd5,
      EV_OUT_ORDER = 3'd6
   } frame_event_type;

   // Summary of a frame whose final word has just been taken in.
   typedef struct packed {
      logic       judged;
      logic       crc_ok;
      logic [7:0] ftype;
      logic [7:0] total;
      logic [7:0] seq;
      logic [7:0] len;
   } verdict_type;

   // MSB-first CRC-8 update over one byte, no reflection.
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
      end
      return v;
   endfunction

endpackage

### hdl/crc8pfr_frame.sv
// Frame parser: byte position, header capture, sync check and running CRC.
module crc8pfr_frame
   import crc8pfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   output verdict_type verdict
);

   logic [8:0] pos_ff, pos_in;
   logic       good_ff, good_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] total_ff, total_in;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] rcrc_ff, rcrc_in;
   logic       in_header_crc;
   logic       in_payload;
   logic [9:0] frame_len;
   logic [9:0] need_len;
   logic       drop;

   always_comb begin
      in_header_crc = (pos_ff >= POS_TYPE) && (pos_ff <= POS_LEN);
      in_payload    = (pos_ff >= POS_PAYLOAD) && ((pos_ff - POS_PAYLOAD) < {1'b0, len_ff});

      good_in = good_ff;
      if ((pos_ff == POS_SYNC_FIRST) && (data_byte != SYNC_FIRST)) begin
         good_in = 1'b0;
      end
      if ((pos_ff == POS_SYNC_SECOND) && (data_byte != SYNC_SECOND)) begin
         good_in = 1'b0;
      end

      crc_in   = (in_header_crc || in_payload) ? crc8_next(crc_ff, data_byte) : crc_ff;
      type_in  = (pos_ff == POS_TYPE)  ? data_byte : type_ff;
      total_in = (pos_ff == POS_TOTAL) ? data_byte : total_ff;
      seq_in   = (pos_ff == POS_SEQ)   ? data_byte : seq_ff;
      len_in   = (pos_ff == POS_LEN)   ? data_byte : len_ff;
      rcrc_in  = (pos_ff == POS_CRC)   ? data_byte : rcrc_ff;

      frame_len = {1'b0, pos_ff} + 10'd1;
      need_len  = {1'b0, POS_PAYLOAD} + {2'b00, len_in};
      drop      = (frame_len < {1'b0, POS_PAYLOAD}) || !good_in || (frame_len < need_len);

      verdict.judged = last_byte && !drop;
      verdict.crc_ok = (crc_in == rcrc_in);
      verdict.ftype  = type_in;
      verdict.total  = total_in;
      verdict.seq    = seq_in;
      verdict.len    = len_in;

      if (last_byte) begin
         pos_in = '0;
      end else if (pos_ff == POS_MAX) begin
         pos_in = pos_ff;
      end else begin
         pos_in = pos_ff + 9'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         good_ff  <= 1'b1;
         crc_ff   <= CRC_INIT;
         type_ff  <= '0;
         total_ff <= '0;
         seq_ff   <= '0;
         len_ff   <= '0;
         rcrc_ff  <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         good_ff  <= last_byte ? 1'b1 : good_in;
         crc_ff   <= last_byte ? CRC_INIT : crc_in;
         type_ff  <= type_in;
         total_ff <= total_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         rcrc_ff  <= rcrc_in;
      end
   end

   `include "assert_macros.svh"

   `ASSERT_CLK(a_frame_restart, (step && last_byte) |=> (pos_ff == '0 && good_ff && crc_ff == CRC_INIT), "Frame state not cleared after the final word.")

endmodule

### hdl/crc8pfr_track.sv
// Sequence and fill tracking that turns a judged frame into a reply.
module crc8pfr_track
   import crc8pfr_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = 4096,
   localparam int unsigned FillW = $clog2(STORE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  verdict_type      verdict,
   output reply_kind_type   kind,
   output frame_event_type  event_code,
   output logic [FillW-1:0] fill_level
);

   localparam logic [FillW:0] DepthLimit = (FillW + 1)'(STORE_DEPTH);

   logic [FillW-1:0] fill_ff, fill_in;
   logic [7:0]       exp_ff, exp_in;
   logic [FillW-1:0] fill_base;
   logic [7:0]       exp_base;
   logic [FillW:0]   fill_sum;

   always_comb begin
      fill_base = (verdict.seq == SEQ_FIRST) ? '0 : fill_ff;
      exp_base  = (verdict.seq == SEQ_FIRST) ? SEQ_FIRST : exp_ff;
      fill_sum  = {1'b0, fill_base} + (FillW + 1)'(verdict.len);

      kind       = REPLY_ACK;
      event_code = EV_NONE;
      fill_in    = fill_ff;
      exp_in     = exp_ff;

      if (!verdict.crc_ok) begin
         kind = REPLY_NACK;
      end else begin
         unique case (verdict.ftype)
            TYPE_DATA: begin
               exp_in  = exp_base;
               fill_in = fill_base;
               if (verdict.seq != exp_base) begin
                  kind       = REPLY_NACK;
                  event_code = EV_OUT_ORDER;
               end else if (fill_sum > DepthLimit) begin
                  fill_in    = '0;
                  event_code = EV_OVERFLOW;
               end else if (verdict.seq == verdict.total) begin
                  fill_in    = '0;
                  exp_in     = '0;
                  event_code = EV_COMPLETE;
               end else begin
                  fill_in    = fill_sum[FillW-1:0];
                  exp_in     = exp_base + 8'd1;
                  event_code = EV_STORED;
               end
            end
            TYPE_START: event_code = EV_START;
            TYPE_STOP:  event_code = EV_STOP;
            default:    event_code = EV_NONE;
         endcase
      end

      fill_level = fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         exp_ff  <= '0;
      end else if (step && verdict.judged) begin
         fill_ff <= fill_in;
         exp_ff  <= exp_in;
      end
   end

   `include "assert_macros.svh"

   `ASSERT_NEVER(a_fill_bounded, {1'b0, fill_ff} > DepthLimit, "Fill level passed the store depth.")

endmodule

### hdl/crc8_packet_frame_receiver.sv
// Top level of the CRC-8 framed packet receiver.
// The receiver takes one word per cycle, back to back, unless the input stalls, and gives one
// reply word for each complete frame with a good header; a word is held in the input register
// and, when it advances, its reply is registered in the result register. The input stalls
// only while a final word waits for a full result register that is itself stalled. The fill
// level counts payload bytes of the current data set and never exceeds STORE_DEPTH.
module crc8_packet_frame_receiver
   import crc8pfr_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = 4096,
   localparam int unsigned FillW = $clog2(STORE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_reply_kind,
   output logic [7:0]       rsp_reply_seq,
   output logic [2:0]       rsp_frame_event,
   output logic [FillW-1:0] rsp_fill_level
);

   logic             in_vld_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic             rsp_free;
   logic             advance;
   verdict_type      verdict;
   reply_kind_type   kind;
   frame_event_type  event_code;
   logic [FillW-1:0] fill_level;

   logic             out_vld_ff, out_vld_in;
   reply_kind_type   out_kind_ff;
   logic [7:0]       out_seq_ff;
   frame_event_type  out_event_ff;
   logic [FillW-1:0] out_fill_ff;

   assign rsp_free  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && (rsp_free || !in_last_ff);
   assign req_stall = in_vld_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   crc8pfr_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .verdict   (verdict)
   );

   crc8pfr_track #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .verdict    (verdict),
      .kind       (kind),
      .event_code (event_code),
      .fill_level (fill_level)
   );

   always_comb begin
      if (advance && verdict.judged) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && verdict.judged) begin
         out_kind_ff  <= kind;
         out_seq_ff   <= verdict.seq;
         out_event_ff <= event_code;
         out_fill_ff  <= fill_level;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_reply_kind  = out_kind_ff;
   assign rsp_reply_seq   = out_seq_ff;
   assign rsp_frame_event = out_event_ff;
   assign rsp_fill_level  = out_fill_ff;

   `include "assert_macros.svh"

   `ASSERT_CLK(a_stall_cause, req_stall |-> (in_vld_ff && in_last_ff && out_vld_ff && rsp_stall), "Input stalled without a waiting final word.")
   `ASSERT_CLK(a_reply_source, (out_vld_ff && !$past(out_vld_ff)) |-> $past(advance && in_last_ff), "Reply raised without a final word.")

endmodule

### verif/crc8_frame_checker.sv
// Checker for the framed packet receiver: predicts reply words and compares them.
`timescale 1ns / 1ps

module crc8_frame_checker
   import crc8pfr_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = 4096,
   parameter int unsigned FILL_W = $clog2(STORE_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_reply_kind,
   input  logic [7:0]        rsp_reply_seq,
   input  logic [2:0]        rsp_frame_event,
   input  logic [FILL_W-1:0] rsp_fill_level,
   output int                mismatch_count,
   output int                outstanding
);

   typedef struct {
      reply_kind_type    kind;
      logic [7:0]        seq;
      frame_event_type   ev;
      logic [FILL_W-1:0] fill;
   } reply_word_type;

   reply_word_type replies_due[$];
   reply_word_type due;

   logic [8:0]  frame_pos;
   logic        sync_ok;
   logic [7:0]  crc_acc;
   logic [7:0]  f_type, f_total, f_seq, f_len, f_crc;
   int unsigned fill_bytes;
   logic [7:0]  next_seq;
   int          errors = 0;

   function automatic logic [7:0] crc8_shift(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
      return r;
   endfunction

   task automatic clear_frame();
      frame_pos = '0;
      sync_ok   = 1'b1;
      crc_acc   = CRC_INIT;
   endtask

   // Advances the frame state by one word and queues a reply when a frame is judged.
   task automatic take_word(input logic [7:0] b, input logic fin);
      logic [8:0]     p;
      int             flen;
      reply_word_type r;
      p = frame_pos;
      if (p == POS_SYNC_FIRST && b != SYNC_FIRST) sync_ok = 1'b0;
      if (p == POS_SYNC_SECOND && b != SYNC_SECOND) sync_ok = 1'b0;
      if (p >= POS_TYPE && p <= POS_LEN) crc_acc = crc8_shift(crc_acc, b);
      case (p)
         POS_TYPE:  f_type  = b;
         POS_TOTAL: f_total = b;
         POS_SEQ:   f_seq   = b;
         POS_LEN:   f_len   = b;
         POS_CRC:   f_crc   = b;
         default: ;
      endcase
      if (p >= POS_PAYLOAD && int'(p) - int'(POS_PAYLOAD) < int'(f_len)) begin
         crc_acc = crc8_shift(crc_acc, b);
      end
      if (p != POS_MAX) frame_pos = p + 9'd1;
      if (!fin) return;

      flen = int'(p) + 1;
      if (flen < int'(POS_PAYLOAD) || !sync_ok || flen < int'(POS_PAYLOAD) + int'(f_len)) begin
         clear_frame();
         return;
      end
      r.kind = REPLY_ACK;
      r.seq  = f_seq;
      r.ev   = EV_NONE;
      if (crc_acc != f_crc) begin
         r.kind = REPLY_NACK;
      end else if (f_type == TYPE_DATA) begin
         if (f_seq == SEQ_FIRST) begin
            fill_bytes = 0;
            next_seq   = SEQ_FIRST;
         end
         if (f_seq != next_seq) begin
            r.kind = REPLY_NACK;
            r.ev   = EV_OUT_ORDER;
         end else if (fill_bytes + f_len > STORE_DEPTH) begin
            fill_bytes = 0;
            r.ev       = EV_OVERFLOW;
         end else begin
            fill_bytes += f_len;
            next_seq   += 8'd1;
            if (f_seq == f_total) begin
               fill_bytes = 0;
               next_seq   = '0;
               r.ev       = EV_COMPLETE;
            end else begin
               r.ev = EV_STORED;
            end
         end
      end else if (f_type == TYPE_START) begin
         r.ev = EV_START;
      end else if (f_type == TYPE_STOP) begin
         r.ev = EV_STOP;
      end
      r.fill = FILL_W'(fill_bytes);
      replies_due.push_back(r);
      clear_frame();
   endtask

   task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         f_type     = '0;
         f_total    = '0;
         f_seq      = '0;
         f_len      = '0;
         f_crc      = '0;
         fill_bytes = 0;
         next_seq   = '0;
         replies_due.delete();
      end else begin
         if (req_valid && !req_stall) take_word(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $display("%0t: reply word with none expected, got kind %0d seq %0d event %0d fill %0d",
                        $time, rsp_reply_kind, rsp_reply_seq, rsp_frame_event, rsp_fill_level);
               errors++;
            end else begin
               due = replies_due.pop_front();
               check_field("reply_kind", 16'(due.kind), 16'(rsp_reply_kind));
               check_field("reply_seq", 16'(due.seq), 16'(rsp_reply_seq));
               check_field("frame_event", 16'(due.ev), 16'(rsp_frame_event));
               check_field("fill_level", 16'(due.fill), 16'(rsp_fill_level));
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= replies_due.size();
   end

endmodule

### verif/crc8_packet_frame_receiver_tb.sv
// Testbench top for the framed packet receiver: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module crc8_packet_frame_receiver_tb
   import crc8pfr_pkg::*;
();

   localparam int unsigned STORE_DEPTH = 4096;
   localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_data_byte = 8'h00;
   logic              req_last_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_reply_kind;
   logic [7:0]        rsp_reply_seq;
   logic [2:0]        rsp_frame_event;
   logic [FILL_W-1:0] rsp_fill_level;
   int                mismatch_count;
   int                outstanding;

   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_trigger = 0;
   int         hold_seen = 0;
   int         hold_left = 0;
   int         words_sent = 0;
   logic [7:0] frame_bytes[$];
   logic [7:0] set_total = 8'd0;
   logic [7:0] set_next = SEQ_FIRST;

   crc8_packet_frame_receiver #(.STORE_DEPTH(STORE_DEPTH)) dut (.*);

   crc8_frame_checker #(.STORE_DEPTH(STORE_DEPTH)) frame_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The result side stalls at random, or for a long stretch when asked.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_trigger) begin
         rsp_stall <= 1'b1;
         hold_left <= 90;
         hold_seen <= hold_trigger;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   function automatic logic [7:0] frame_crc();
      logic [7:0] acc;
      logic       fb;
      acc = CRC_INIT;
      for (int i = int'(POS_TYPE); i < frame_bytes.size(); i++) begin
         if (i != int'(POS_CRC)) begin
            for (int k = 7; k >= 0; k--) begin
               fb  = acc[7] ^ frame_bytes[i][k];
               acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
         end
      end
      return acc;
   endfunction

   function automatic logic [7:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return 8'($urandom_range(0, 8));
      if (r < 97) return 8'($urandom_range(9, 40));
      return 8'($urandom_range(41, 255));
   endfunction

   task automatic build_frame(input logic [7:0] ftype, input logic [7:0] total,
                              input logic [7:0] seq, input logic [7:0] len, input bit bad_crc);
      logic [7:0] c;
      frame_bytes = {SYNC_FIRST, SYNC_SECOND, ftype, 8'($urandom), total, seq, len, 8'h00};
      repeat (len) frame_bytes.push_back(8'($urandom));
      c = frame_crc();
      if (bad_crc) c ^= 8'(1 << $urandom_range(0, 7));
      frame_bytes[POS_CRC] = c;
   endtask

   task automatic send_word(input logic [7:0] b, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_word(frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   task automatic next_in_set(input logic [7:0] len, input bit bad_crc);
      if (set_next > set_total) begin
         set_total = 8'($urandom_range(1, 8));
         set_next  = SEQ_FIRST;
      end
      build_frame(TYPE_DATA, set_total, set_next, len, bad_crc);
      if (!bad_crc) set_next++;
   endtask

   // Mostly well-formed data sets, with broken and foreign frames mixed in.
   task automatic random_frame();
      int         pick;
      int         cut;
      logic [7:0] ftype;
      logic [7:0] wrong_seq;
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
         next_in_set(pick_len(), 1'b0);
      end else if (pick < 68) begin
         next_in_set(pick_len(), 1'b1);
      end else if (pick < 73) begin
         wrong_seq = set_next + 8'($urandom_range(1, 200));
         build_frame(TYPE_DATA, set_total, wrong_seq, pick_len(), 1'b0);
      end else if (pick < 80) begin
         ftype = (pick < 75) ? TYPE_START : (pick < 78) ? TYPE_STOP : 8'($urandom);
         build_frame(ftype, 8'($urandom), 8'($urandom), pick_len(), 1'b0);
      end else if (pick < 84) begin
         build_frame(TYPE_DATA, set_total, set_next, 8'($urandom_range(1, 20)), 1'b0);
         cut = $urandom_range(1, frame_bytes[POS_LEN]);
         repeat (cut) void'(frame_bytes.pop_back());
      end else if (pick < 88) begin
         build_frame(TYPE_START, 8'($urandom), 8'($urandom), 8'd0, 1'b0);
         cut = $urandom_range(1, 7);
         repeat (cut) void'(frame_bytes.pop_back());
      end else if (pick < 92) begin
         build_frame(TYPE_START, 8'($urandom), 8'($urandom), pick_len(), 1'b0);
         cut = $urandom_range(0, 1);
         frame_bytes[cut] ^= 8'($urandom_range(1, 255));
      end else if (pick < 97) begin
         next_in_set(pick_len(), 1'b0);
         cut = $urandom_range(1, 6);
         repeat (cut) frame_bytes.push_back(8'($urandom));
      end else begin
         frame_bytes = {};
         cut = $urandom_range(1, 12);
         repeat (cut) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
   endtask

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int phase_end;
      repeat (6) @(posedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 28;
      recv_idle_pct <= 56;

      frame_bytes = {SYNC_FIRST};
      send_frame();
      build_frame(TYPE_START, 8'h00, 8'h00, 8'd0, 1'b0);
      void'(frame_bytes.pop_back());
      send_frame();
      build_frame(TYPE_START, 8'hFF, 8'h01, 8'd0, 1'b0);
      frame_bytes[POS_SYNC_FIRST] = 8'h00;
      send_frame();
      build_frame(TYPE_STOP, 8'h00, 8'h02, 8'd0, 1'b0);
      frame_bytes[POS_SYNC_SECOND] = 8'hFF;
      send_frame();
      build_frame(TYPE_START, 8'hFF, 8'h00, 8'd0, 1'b0);
      send_frame();
      build_frame(TYPE_STOP, 8'h00, 8'hFF, 8'd0, 1'b0);
      send_frame();
      build_frame(8'hFF, 8'h12, 8'h34, 8'd2, 1'b0);
      send_frame();
      build_frame(TYPE_DATA, 8'd2, SEQ_FIRST, 8'd4, 1'b1);
      send_frame();
      build_frame(TYPE_DATA, 8'd2, 8'd2, 8'd1, 1'b0);
      send_frame();
      build_frame(TYPE_DATA, 8'd2, SEQ_FIRST, 8'd3, 1'b0);
      send_frame();
      build_frame(TYPE_DATA, 8'd2, 8'd2, 8'd4, 1'b0);
      repeat (2) void'(frame_bytes.pop_back());
      send_frame();
      build_frame(TYPE_DATA, 8'd2, 8'd2, 8'd0, 1'b0);
      repeat (3) frame_bytes.push_back(8'($urandom));
      send_frame();

      phase_end = words_sent + 300;
      while (words_sent < phase_end) random_frame();
      send_idle_pct <= 56;
      recv_idle_pct <= 28;
      phase_end = words_sent + 300;
      while (words_sent < phase_end) random_frame();
      send_idle_pct <= 0;
      recv_idle_pct <= 0;

      // Hold the result side off while short frames keep arriving back to back.
      hold_trigger <= hold_trigger + 1;
      repeat (14) begin
         build_frame(TYPE_START, 8'($urandom), 8'($urandom), 8'd0, 1'b0);
         send_frame();
      end

      // A frame long enough to saturate the byte position.
      build_frame(TYPE_START, 8'hFF, 8'h80, 8'd0, 1'b0);
      repeat (520) frame_bytes.push_back(8'($urandom));
      send_frame();

      phase_end = words_sent + 300;
      while (words_sent < phase_end) random_frame();

      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
